FILE: design/l2nv_pkg.sv
// Package: shared constants, state encoding and register indexes for the L2 normalizer.
`timescale 1ns / 1ps
package l2nv_pkg;

	localparam int MAX_LENGTH_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int HL_W     = 7;   // head_length register width
	localparam int EPS_W    = 32;  // epsilon register width
	localparam int CFG_W    = 32;  // config write data width
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W    = 16;  // Q1.14 result width
	localparam int SUM_W    = 63;  // square sum, saturates at 2^62
	localparam int QUO_W    = 57;  // floor(2^56 / S)
	localparam int RES_W    = 58;  // square root working register
	localparam int F_W      = 29;  // scale factor, at most 2^28
	localparam int OUT_SHIFT = 14;
	localparam logic [OUT_W-1:0] OUT_MAX = 16'd16384;
	localparam logic [63:0] SUM_CAP = 64'h4000_0000_0000_0000;
	localparam logic [HL_W-1:0]  HEAD_LENGTH_RST = 7'd64;
	localparam logic [EPS_W-1:0] EPSILON_RST     = 32'd17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEAD_LENGTH = 2'd0,
		REG_EPSILON     = 2'd1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_FLUSH,
		ST_PREP,
		ST_DIV,
		ST_SQINIT,
		ST_SQRT,
		ST_RD,
		ST_MUL,
		ST_RND,
		ST_OUT
	} state_t;

endpackage

FILE: design/l2_normalize_vector.sv
// L2 normalizer top level: element store, square accumulator, divide/root unit, output scaler.
// From the last sample beat of a group to the first result beat: 2 square stages,
//   1 setup, 57 divide steps, 1 root setup, 29 root steps, read, multiply, round; each
//   result then passes read, multiply, round and its beat, held while out_stall is high.
// Throughput: one sample beat per cycle while loading; no samples are taken from the end
//   of a group's load until its last result beat. Set by the bit-serial divider and root
//   and the single store read port. Reset: async active low; clears control, fill count, sum.
`timescale 1ns / 1ps
module l2_normalize_vector
	import l2nv_pkg::*;
#(
	parameter int MAX_LENGTH  = MAX_LENGTH_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration
	input  logic                   cfg_write,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	// sample channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [OUT_W-1:0] normalized,
	output logic                   last
);

	localparam int AW  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int CW  = $clog2(MAX_LENGTH + 1);
	localparam int PW  = SAMPLE_BITS + F_W;
	localparam logic [HL_W-1:0] MAX_LEN = HL_W'(MAX_LENGTH);

	state_t state_q, state_d;

	// config registers
	logic [HL_W-1:0]  head_length_q;
	logic [EPS_W-1:0] epsilon_q;

	// load path
	logic [CW-1:0]          fill_q;
	logic [HL_W-1:0]        grp_len;
	logic                   in_acc;
	logic                   grp_done;
	logic [SAMPLE_BITS-1:0] mag_s1;
	logic                   v_s1, done_s1;
	logic [2*SAMPLE_BITS-1:0] sq_s2;
	logic                   v_s2, done_s2;
	logic [SUM_W-1:0]       sum_q;
	logic [63:0]            sq64, sum64, sum_next;

	// divide / root
	logic [SUM_W-1:0] s_q;
	logic             zero_q;
	logic [63:0]      s_sum;
	logic [5:0]       cnt_q;
	logic [SUM_W-1:0] rem_q;
	logic [63:0]      trial;
	logic [QUO_W-1:0] quo_q;
	logic [QUO_W-1:0] n_q;
	logic [RES_W-1:0] res_q;
	logic [QUO_W-1:0] bit_q;
	logic [RES_W-1:0] rb;

	// emit path
	logic [CW-1:0]          k_q;
	logic [SAMPLE_BITS-1:0] rd_data_q;
	logic                   neg_q;
	logic [PW-1:0]          prod_q;
	logic [F_W-1:0]         factor;
	logic [SAMPLE_BITS-1:0] rd_mag;
	logic [PW:0]            rnd;
	logic [OUT_W-1:0]       mag_out;
	logic signed [OUT_W-1:0] norm_q;
	logic                   last_q;
	logic                   out_acc;

	logic [SAMPLE_BITS-1:0] store_mem [MAX_LENGTH];

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_length_q <= HEAD_LENGTH_RST;
			epsilon_q     <= EPSILON_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HEAD_LENGTH: head_length_q <= cfg_data[HL_W-1:0];
				REG_EPSILON:     epsilon_q     <= cfg_data[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	// effective length: zero acts as one, above depth clamps to depth
	always_comb begin
		if (head_length_q == '0)
			grp_len = HL_W'(1);
		else if (head_length_q > MAX_LEN)
			grp_len = MAX_LEN;
		else
			grp_len = head_length_q;
	end

	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid && !out_stall;
	assign grp_done = (HL_W'(fill_q) + HL_W'(1)) >= grp_len;

	// ---------------- state machine ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:   if (in_acc && grp_done) state_d = ST_FLUSH;
			ST_FLUSH:  if (v_s2 && done_s2) state_d = ST_PREP;
			ST_PREP:   state_d = ST_DIV;
			ST_DIV:    if (cnt_q == '0) state_d = ST_SQINIT;
			ST_SQINIT: state_d = ST_SQRT;
			ST_SQRT:   if (bit_q[0]) state_d = ST_RD;
			ST_RD:     state_d = ST_MUL;
			ST_MUL:    state_d = ST_RND;
			ST_RND:    state_d = ST_OUT;
			ST_OUT: begin
				if (out_acc)
					state_d = last_q ? ST_LOAD : ST_RD;
			end
			default:   state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_LOAD);
		out_valid = (state_q == ST_OUT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_LOAD;
		else
			state_q <= state_d;
	end

	// ---------------- element store ----------------
	always_ff @(posedge clk) begin
		if (in_acc)
			store_mem[fill_q[AW-1:0]] <= sample;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD)
			rd_data_q <= store_mem[k_q[AW-1:0]];
	end

	// ---------------- square accumulate pipeline ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			done_s1 <= 1'b0;
			v_s2    <= 1'b0;
			done_s2 <= 1'b0;
			fill_q  <= '0;
			sum_q   <= '0;
		end else begin
			v_s1    <= in_acc;
			done_s1 <= in_acc && grp_done;
			v_s2    <= v_s1;
			done_s2 <= done_s1;
			if (in_acc)
				fill_q <= fill_q + CW'(1);
			else if (state_q == ST_OUT && out_acc && last_q)
				fill_q <= '0;
			if (v_s2)
				sum_q <= sum_next[SUM_W-1:0];
			else if (state_q == ST_OUT && out_acc && last_q)
				sum_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			mag_s1 <= sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
		if (v_s1)
			sq_s2 <= mag_s1 * mag_s1;
	end

	// saturating add at 2^62
	always_comb begin
		sq64  = 64'(sq_s2);
		sum64 = 64'(sum_q);
		if (sum64 > (SUM_CAP - sq64))
			sum_next = SUM_CAP;
		else
			sum_next = sum64 + sq64;
	end

	// ---------------- S, divider, root ----------------
	assign s_sum = 64'(sum_q) + 64'(epsilon_q);
	assign trial = {rem_q, (cnt_q == 6'd56)};
	assign rb    = res_q + RES_W'(bit_q);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_PREP: begin
				s_q    <= (s_sum > SUM_CAP) ? SUM_CAP[SUM_W-1:0] : s_sum[SUM_W-1:0];
				zero_q <= (s_sum == 64'd0);
				rem_q  <= '0;
				quo_q  <= '0;
				cnt_q  <= 6'd56;
			end
			ST_DIV: begin
				if (trial >= 64'(s_q)) begin
					rem_q <= SUM_W'(trial - 64'(s_q));
					quo_q <= {quo_q[QUO_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[SUM_W-1:0];
					quo_q <= {quo_q[QUO_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
			end
			ST_SQINIT: begin
				n_q   <= quo_q;
				res_q <= '0;
				bit_q <= {1'b1, {(QUO_W-1){1'b0}}};
				k_q   <= '0;
			end
			ST_SQRT: begin
				if (RES_W'(n_q) >= rb) begin
					n_q   <= QUO_W'(RES_W'(n_q) - rb);
					res_q <= (res_q >> 1) + RES_W'(bit_q);
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_OUT: begin
				if (out_acc)
					k_q <= k_q + CW'(1);
			end
			default: ;
		endcase
	end

	// ---------------- scale, round, saturate ----------------
	assign factor  = zero_q ? '0 : res_q[F_W-1:0];
	assign rd_mag  = rd_data_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-rd_data_q) : rd_data_q;
	assign rnd     = ((PW+1)'(prod_q) + (PW+1)'(1 << (OUT_SHIFT-1))) >> OUT_SHIFT;
	assign mag_out = (rnd > (PW+1)'(OUT_MAX)) ? OUT_MAX : rnd[OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= PW'(rd_mag) * PW'(factor);
			neg_q  <= rd_data_q[SAMPLE_BITS-1];
		end
		if (state_q == ST_RND) begin
			norm_q <= neg_q ? -$signed(mag_out) : $signed(mag_out);
			last_q <= (k_q + CW'(1)) == fill_q;
		end
	end

	assign normalized = norm_q;
	assign last       = last_q;

endmodule

FILE: design/l2nv_checker.sv
// Checker: port-level properties of the L2 normalizer, bound to the top level.
`timescale 1ns / 1ps
module l2nv_checker
	import l2nv_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [OUT_W-1:0] normalized,
	input logic                    last
);

	// no sample beat is taken while results are being emitted
	a_no_load_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("sample channel open during emission");

	// result stays within Q1.14 unit range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (normalized <= $signed(OUT_MAX) && normalized >= -$signed(OUT_MAX)))
		else $error("normalized out of range");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(normalized) && $stable(last))
		else $error("stalled result changed");

	// after the last beat of a group, input reopens
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !in_stall && !out_valid)
		else $error("input not reopened after group");

endmodule

bind l2_normalize_vector l2nv_checker u_l2nv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.normalized (normalized),
	.last       (last)
);

FILE: verif/tb.sv
// Testbench for the L2 normalizer: random and directed samples checked against a predictor.
`timescale 1ns / 1ps
module tb;
	import l2nv_pkg::*;

	localparam int GROUP_MAX   = 64;
	localparam int WATCH_LIMIT = 6000;  // cycles with no beat on either channel
	localparam int DRAIN_WAIT  = 150;   // covers divide/root latency after a load
	localparam int HOLD_LONG   = 500;   // long receiver hold-off
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;  // unmapped register index

	typedef struct {
		logic signed [OUT_W-1:0] normalized;
		logic                    last;
	} norm_beat_t;

	// Scoreboard: carries its own copy of the group state and the expected beats.
	class norm_scoreboard;
		logic [HL_W-1:0]         head_len;
		logic [EPS_W-1:0]        eps;
		logic signed [15:0]      group_elems [GROUP_MAX];
		logic [63:0]             energy;
		int                      fill;
		norm_beat_t              expected_q [$];
		int                      errors, samples_seen, beats_seen, groups_done;

		function new();
			head_len = HEAD_LENGTH_RST;
			eps = EPSILON_RST;
			energy = 0;
			fill = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == REG_HEAD_LENGTH)
				head_len = data[HL_W-1:0];
			else if (idx == REG_EPSILON)
				eps = data[EPS_W-1:0];
		endfunction

		// integer square root, bit by bit from the top
		function logic [63:0] root_of(logic [63:0] n);
			logic [63:0] r, t;
			r = 0;
			for (int b = 29; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= n)
					r = t;
			end
			return r;
		endfunction

		function void note_sample(logic signed [15:0] x);
			logic [63:0] mag, sq, s, f, m, r;
			int len;
			norm_beat_t b;
			samples_seen++;
			mag = (x < 0) ? -64'(x) : 64'(x);
			sq = mag * mag;
			len = (head_len == 0) ? 1 : (head_len > GROUP_MAX) ? GROUP_MAX : int'(head_len);
			if (fill < GROUP_MAX)
				group_elems[fill] = x;
			energy = (energy > SUM_CAP - sq) ? SUM_CAP : energy + sq;
			fill++;
			if (fill < len)
				return;
			s = energy + 64'(eps);
			if (s > SUM_CAP)
				s = SUM_CAP;
			f = (s == 0) ? 0 : root_of((64'd1 << 56) / s);
			if (fill > GROUP_MAX)
				fill = GROUP_MAX;
			for (int k = 0; k < fill; k++) begin
				m = (group_elems[k] < 0) ? -64'(group_elems[k]) : 64'(group_elems[k]);
				r = (m * f + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
				if (r > 64'(OUT_MAX))
					r = 64'(OUT_MAX);
				b.normalized = (group_elems[k] < 0) ? -16'(r) : 16'(r);
				b.last = (k + 1 == fill);
				expected_q.push_back(b);
			end
			groups_done++;
			fill = 0;
			energy = 0;
		endfunction

		function void check_result(logic signed [OUT_W-1:0] n, logic l);
			norm_beat_t e;
			beats_seen++;
			if (expected_q.size() == 0) begin
				$error("unexpected result beat: normalized %0d last %0b", n, l);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (n !== e.normalized) begin
				$error("normalized: expected %0d, actual %0d", e.normalized, n);
				errors++;
			end
			if (l !== e.last) begin
				$error("last: expected %0b, actual %0b", e.last, l);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write = 0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_HEAD_LENGTH;
	logic [CFG_W-1:0] cfg_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [SAMPLE_BITS_DEF-1:0] sample = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [OUT_W-1:0] normalized;
	logic last;

	norm_scoreboard sb = new();
	int in_idle_pct = 0, out_idle_pct = 0;
	int hold_req = 0, hold_left = 0;
	int quiet_cycles = 0;

	l2_normalize_vector dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.normalized(normalized), .last(last)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Monitors: values sampled here are the pre-edge ones, so a beat is exactly
	// what the block saw at this edge.
	always @(posedge clk) begin
		if (in_valid && !in_stall)
			sb.note_sample(sample);
		if (out_valid && !out_stall)
			sb.check_result(normalized, last);
	end

	// Receiver: random stall, or a long hold-off counted down here.
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < out_idle_pct);
		end
	end

	// Watchdog: any beat restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("l2_normalize_vector regression: fail");
			$finish;
		end
	end

	// One sample beat; optional idle cycles come first, valid held until taken.
	task automatic send_sample(input logic signed [15:0] v);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= v;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (sb.expected_q.size() != 0)
			@(posedge clk);
	endtask

	// Register write only with nothing owed, after the block has settled.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
		if (in_valid)
			stop_sending();
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
		cfg_write <= 1'b0;
	endtask

	// Mix of full-range, small and extreme elements.
	function automatic logic signed [15:0] pick_sample();
		int sel;
		sel = $urandom_range(9);
		if (sel < 5)
			return 16'($urandom);
		else if (sel < 8)
			return 16'($signed($urandom_range(128)) - 64);
		else
			return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
	endfunction

	function automatic logic [CFG_W-1:0] pick_length();
		int sel;
		sel = $urandom_range(19);
		if (sel < 14)
			return $urandom_range(8, 1);
		else if (sel < 17)
			return $urandom_range(63, 9);
		else if (sel < 18)
			return 64;
		else
			return ($urandom_range(1)) ? 0 : $urandom_range(127, 65);  // out of range
	endfunction

	function automatic logic [CFG_W-1:0] pick_eps();
		case ($urandom_range(4))
			0: return EPSILON_RST;
			1: return 0;
			2: return 32'hffff_ffff;
			3: return $urandom_range(1 << 20);
			default: return $urandom;
		endcase
	endfunction

	// One phase of random traffic: several settings, mostly whole groups, with
	// a ragged tail now and then so the next length change lands mid-group.
	task automatic random_phase(input int n_items);
		int sent, len, groups, tail;
		sent = 0;
		while (sent < n_items) begin
			write_reg(REG_HEAD_LENGTH, pick_length());
			write_reg(REG_EPSILON, pick_eps());
			len = (sb.head_len == 0) ? 1 : (sb.head_len > GROUP_MAX) ? GROUP_MAX
				: int'(sb.head_len);
			groups = (len > 8) ? 1 : $urandom_range(4, 1);
			for (int i = 0; i < len * groups; i++)
				send_sample(pick_sample());
			sent += len * groups;
			if ($urandom_range(3) == 0) begin
				tail = $urandom_range(3, 1);
				for (int i = tail; i > 0; i--)
					send_sample(pick_sample());
				sent += tail;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		write_reg(REG_SPARE, 32'h0000_0003);         // unmapped index, no effect
		write_reg(REG_HEAD_LENGTH, 4);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(16'sh0001);
		write_reg(REG_HEAD_LENGTH, 1);
		send_sample(-16'sd1);
		write_reg(REG_HEAD_LENGTH, 0);               // zero length acts as one
		send_sample(16'sd12345);
		write_reg(REG_EPSILON, 0);                   // zero energy: all outputs zero
		write_reg(REG_HEAD_LENGTH, 2);
		send_sample(16'sd0);
		send_sample(16'sd0);
		write_reg(REG_HEAD_LENGTH, 4);               // grow length to four; shrunk again mid-group
		send_sample(16'sd4096);
		send_sample(-16'sd4096);
		send_sample(16'sd2048);
		write_reg(REG_HEAD_LENGTH, 2);
		send_sample(16'sd1);                         // completes a group of four
		send_sample(16'sd3);                         // epsilon swapped mid-group
		write_reg(REG_EPSILON, 32'hffff_ffff);
		send_sample(-16'sd3);
		write_reg(REG_EPSILON, 17);
		send_sample(16'sd1);                         // tiny energy
		send_sample(-16'sd1);

		// --- long receiver hold-off while the sender keeps pushing ---
		write_reg(REG_HEAD_LENGTH, 6);
		hold_req = HOLD_LONG;
		for (int i = 0; i < 18; i++)
			send_sample(pick_sample());
		stop_sending();
		wait_drained();                              // sender pauses until all is out

		// --- random, three idling regimes ---
		in_idle_pct = 28; out_idle_pct = 87;
		random_phase(55);
		in_idle_pct = 87; out_idle_pct = 28;
		random_phase(55);
		in_idle_pct = 0; out_idle_pct = 0;
		random_phase(55);
		write_reg(REG_HEAD_LENGTH, 127);             // top of register: acts as 64
		write_reg(REG_EPSILON, 0);
		for (int i = 0; i < GROUP_MAX; i++)
			send_sample(pick_sample());
		stop_sending();

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d samples in %0d groups, %0d result beats checked",
			sb.samples_seen, sb.groups_done, sb.beats_seen);
		$display("lengths 0..127, epsilon 0..max, long hold-off and three stall mixes");
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("l2_normalize_vector regression: pass");
		end else begin
			$display("l2_normalize_vector regression: fail");
		end
		$finish;
	end

endmodule

FILE: l2_normalize_vector.f
design/l2nv_pkg.sv
design/l2_normalize_vector.sv
design/l2nv_checker.sv
verif/tb.sv
